>>> rtl/hobb_pkg.sv
// Shared types, constants and helpers for the hourly OHLC bar builder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hobb_pkg;

	// field widths
	localparam int TIME_W     = 17;
	localparam int WIN_W      = 18;
	localparam int PRICE_W    = 48;
	localparam int VOL_W      = 40;
	localparam int VOLD_W     = 41;
	localparam int ALU_W      = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	// remainder unit: one dividend bit per step
	localparam int DIV_STEPS = TIME_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	// time constants
	localparam logic [TIME_W-1:0] MINUTE_SECONDS = TIME_W'(60);
	localparam logic [TIME_W-1:0] BAR_MIN        = TIME_W'(60);
	localparam logic [TIME_W-1:0] BAR_MAX        = TIME_W'(86400);
	localparam logic [TIME_W-1:0] BAR_RESET      = TIME_W'(60 * 60);
	localparam logic [WIN_W-1:0]  DAY_SECONDS    = WIN_W'(86400);
	localparam logic [WIN_W-1:0]  TWO_DAYS       = WIN_W'(2 * 86400);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESUME_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RESUME_TIME   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BAR_SECONDS   = CFG_IDX_W'(2);

	// configuration seen by the sequencer (bar length already clamped)
	typedef struct packed {
		logic              resume_enable;
		logic [TIME_W-1:0] resume_time;
		logic [TIME_W-1:0] bar_len;
	} hobb_cfg_t;

	// shared compare/subtract unit
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} hobb_alu_req_t;

	typedef struct packed {
		logic             lt;
		logic [ALU_W-1:0] diff;
	} hobb_alu_rsp_t;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_CHK_RES = 9'b000000010,
		ST_CHK_BEG = 9'b000000100,
		ST_CHK_END = 9'b000001000,
		ST_UPD_HI  = 9'b000010000,
		ST_UPD_LO  = 9'b000100000,
		ST_EMIT    = 9'b001000000,
		ST_DIV     = 9'b010000000,
		ST_FIX     = 9'b100000000
	} hobb_state_t;

	// wrap a window bound below three days into a second of day
	function automatic logic [TIME_W-1:0] day_wrap(input logic [WIN_W-1:0] v);
		logic [WIN_W-1:0] r;
		r = v;
		if (r >= TWO_DAYS) begin
			r = r - TWO_DAYS;
		end else if (r >= DAY_SECONDS) begin
			r = r - DAY_SECONDS;
		end
		return r[TIME_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/hobb_alu.sv
// Shared compare/subtract unit of the bar builder: a - b with borrow.
// Depends on hobb_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module hobb_alu (
	input  wire hobb_pkg::hobb_alu_req_t req,
	output hobb_pkg::hobb_alu_rsp_t      rsp
);
	import hobb_pkg::*;

	logic [ALU_W:0] sub;

	// subtract with one extra bit; the top bit is the borrow, set when a < b
	assign sub      = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.lt   = sub[ALU_W];
	assign rsp.diff = sub[ALU_W-1:0];

endmodule

`default_nettype wire

>>> rtl/hobb_seq.sv
// Sequencer of the bar builder: window state, bar statistics, remainder steps
// and the output register. Depends on hobb_pkg and hobb_alu.
`timescale 1ns / 1ps
`default_nettype none

module hobb_seq (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire hobb_pkg::hobb_cfg_t          cfg,
	input  wire                               tick_valid,
	output logic                              tick_ready,
	input  wire  [hobb_pkg::TIME_W-1:0]       tick_time,
	input  wire  [hobb_pkg::PRICE_W-1:0]      tick_price,
	input  wire  [hobb_pkg::VOL_W-1:0]        tick_cum_volume,
	output logic                              bar_valid,
	input  wire                               bar_ready,
	output logic [hobb_pkg::TIME_W-1:0]       bar_start,
	output logic [hobb_pkg::TIME_W-1:0]       bar_end,
	output logic [hobb_pkg::PRICE_W-1:0]      open_price,
	output logic [hobb_pkg::PRICE_W-1:0]      high_price,
	output logic [hobb_pkg::PRICE_W-1:0]      low_price,
	output logic [hobb_pkg::PRICE_W-1:0]      close_price,
	output logic signed [hobb_pkg::VOLD_W-1:0] volume_traded
);
	import hobb_pkg::*;

	hobb_state_t state_q, state_d;

	// latched tick
	logic [TIME_W-1:0]  t_q;
	logic [PRICE_W-1:0] price_q;
	logic [VOL_W-1:0]   vol_q;

	// window and bar state
	logic               window_open_q;
	logic               has_ticks_q;
	logic [WIN_W-1:0]   window_start_q;
	logic [WIN_W-1:0]   window_end_q;
	logic [PRICE_W-1:0] first_price_q;
	logic [PRICE_W-1:0] max_price_q;
	logic [PRICE_W-1:0] min_price_q;
	logic [PRICE_W-1:0] last_price_q;
	logic [VOL_W-1:0]   first_vol_q;
	logic [VOL_W-1:0]   last_vol_q;

	// remainder unit
	logic [TIME_W-1:0]  div_x_q;
	logic [TIME_W-1:0]  divisor_q;
	logic [TIME_W-1:0]  rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W:0]    rem_shift;

	// output register
	logic               out_valid_q;
	logic               out_free;
	logic [TIME_W-1:0]  out_start_q;
	logic [TIME_W-1:0]  out_end_q;
	logic [PRICE_W-1:0] out_open_q;
	logic [PRICE_W-1:0] out_high_q;
	logic [PRICE_W-1:0] out_low_q;
	logic [PRICE_W-1:0] out_close_q;
	logic [VOLD_W-1:0]  out_vol_q;

	hobb_alu_req_t alu_req;
	hobb_alu_rsp_t alu_rsp;
	logic          tick_xfer;
	logic          closing_lt;

	hobb_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign tick_ready = (state_q == ST_IDLE);
	assign tick_xfer  = tick_valid && tick_ready;
	assign out_free   = !out_valid_q || bar_ready;
	assign rem_shift  = {rem_q, div_x_q[TIME_W-1]};
	assign closing_lt = alu_rsp.lt;

	// select the operands of the shared unit for the current step
	always_comb begin
		alu_req.a = '0;
		alu_req.b = '0;
		case (state_q)
			ST_CHK_RES: begin
				alu_req.a = ALU_W'(t_q);
				alu_req.b = ALU_W'(cfg.resume_time);
			end
			ST_CHK_BEG: begin
				alu_req.a = ALU_W'(t_q);
				alu_req.b = ALU_W'(window_start_q);
			end
			ST_CHK_END: begin
				alu_req.a = ALU_W'(t_q);
				alu_req.b = ALU_W'(window_end_q);
			end
			ST_UPD_HI: begin
				alu_req.a = max_price_q;
				alu_req.b = price_q;
			end
			ST_UPD_LO: begin
				alu_req.a = price_q;
				alu_req.b = min_price_q;
			end
			ST_DIV: begin
				alu_req.a = ALU_W'(rem_shift);
				alu_req.b = ALU_W'(divisor_q);
			end
			ST_FIX: begin
				alu_req.a = ALU_W'(t_q);
				alu_req.b = ALU_W'(rem_q);
			end
			default: begin
				alu_req.a = '0;
				alu_req.b = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_xfer) state_d = ST_CHK_RES;
			end
			ST_CHK_RES: begin
				if (cfg.resume_enable && alu_rsp.lt) state_d = ST_IDLE;
				else if (!window_open_q) state_d = ST_DIV;
				else state_d = ST_CHK_BEG;
			end
			ST_CHK_BEG: begin
				state_d = alu_rsp.lt ? ST_IDLE : ST_CHK_END;
			end
			ST_CHK_END: begin
				if (closing_lt) state_d = has_ticks_q ? ST_UPD_HI : ST_IDLE;
				else state_d = has_ticks_q ? ST_EMIT : ST_DIV;
			end
			ST_UPD_HI: state_d = ST_UPD_LO;
			ST_UPD_LO: state_d = ST_IDLE;
			ST_EMIT: begin
				if (out_free) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST) state_d = ST_FIX;
			end
			ST_FIX: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_open_q <= 1'b0;
			has_ticks_q   <= 1'b0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			// step counter runs only inside the remainder loop
			if (state_q == ST_DIV) cnt_q <= cnt_q + CNT_W'(1);
			else cnt_q <= '0;
			// open the window and mark the bar live
			if (state_q == ST_FIX) begin
				window_open_q <= 1'b1;
				has_ticks_q   <= 1'b1;
			end else if (state_q == ST_CHK_END && closing_lt && !has_ticks_q) begin
				has_ticks_q <= 1'b1;
			end
			// hold a bar until the receiver takes it
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (bar_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (tick_xfer) begin
					t_q     <= tick_time;
					price_q <= tick_price;
					vol_q   <= tick_cum_volume;
				end
			end
			ST_CHK_RES: begin
				// first window: clear the seconds of the tick time
				div_x_q   <= t_q;
				divisor_q <= MINUTE_SECONDS;
				rem_q     <= '0;
			end
			ST_CHK_END: begin
				if (closing_lt) begin
					// start a bar in an empty window
					if (!has_ticks_q) begin
						first_price_q <= price_q;
						max_price_q   <= price_q;
						min_price_q   <= price_q;
						last_price_q  <= price_q;
						first_vol_q   <= vol_q;
						last_vol_q    <= vol_q;
					end
				end else begin
					// skip whole windows: remainder of (t - end) by the bar length
					div_x_q   <= alu_rsp.diff[TIME_W-1:0];
					divisor_q <= cfg.bar_len;
					rem_q     <= '0;
				end
			end
			ST_UPD_HI: begin
				if (alu_rsp.lt) max_price_q <= price_q;
			end
			ST_UPD_LO: begin
				if (alu_rsp.lt) min_price_q <= price_q;
				last_price_q <= price_q;
				last_vol_q   <= vol_q;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_start_q <= day_wrap(window_start_q);
					out_end_q   <= day_wrap(window_end_q);
					out_open_q  <= first_price_q;
					out_high_q  <= max_price_q;
					out_low_q   <= min_price_q;
					out_close_q <= last_price_q;
					out_vol_q   <= {1'b0, last_vol_q} - {1'b0, first_vol_q};
				end
			end
			ST_DIV: begin
				// restoring step: subtract the divisor when it fits
				if (alu_rsp.lt) rem_q <= rem_shift[TIME_W-1:0];
				else rem_q <= alu_rsp.diff[TIME_W-1:0];
				div_x_q <= {div_x_q[TIME_W-2:0], 1'b0};
			end
			ST_FIX: begin
				// new window starts at the tick time less the remainder
				window_start_q <= WIN_W'(alu_rsp.diff[TIME_W-1:0]);
				window_end_q   <= WIN_W'(alu_rsp.diff[TIME_W-1:0]) + WIN_W'(cfg.bar_len);
				first_price_q  <= price_q;
				max_price_q    <= price_q;
				min_price_q    <= price_q;
				last_price_q   <= price_q;
				first_vol_q    <= vol_q;
				last_vol_q     <= vol_q;
			end
			default: begin
			end
		endcase
	end

	assign bar_valid     = out_valid_q;
	assign bar_start     = out_start_q;
	assign bar_end       = out_end_q;
	assign open_price    = out_open_q;
	assign high_price    = out_high_q;
	assign low_price     = out_low_q;
	assign close_price   = out_close_q;
	assign volume_traded = $signed(out_vol_q);

endmodule

`default_nettype wire

>>> rtl/hourly_ohlc_bar_builder.sv
// Hourly OHLC bar builder.
// Ticks enter on the tick channel (tick_valid/tick_ready): second of day, price
// in 48-bit fixed point and cumulative day volume, in time order. Closed bars
// leave on the bar channel (bar_valid/bar_ready) with start, end, open, high,
// low, close and traded volume.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 resume_enable, 1 resume_time, 2 bar_seconds); write only while idle.
// Sequencing: one sequencer around one shared compare/subtract unit handles
// each tick and takes no new tick until done. A tick dropped by the resume
// filter takes only the resume check, a late tick also the window start
// check, a tick inside the window also the window end check and the high and
// low updates; a tick that opens the first window or closes one runs the 17
// one-bit remainder steps. A tick that closes a bar, after its resume, start
// and end checks, waits for the output register to empty and loads the bar.
// A closed bar sits in the output register until bar_ready; while it waits,
// ticks inside the window are still taken, and only a tick that must emit a
// new bar stalls.
// Reset: no window open, bar length 3600 s, resume filter off, no bar pending.
// Depends on hobb_pkg, hobb_seq and hobb_alu.
`timescale 1ns / 1ps
`default_nettype none

module hourly_ohlc_bar_builder (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [hobb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [hobb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                 tick_valid,
	output logic                                tick_ready,
	input  wire  [hobb_pkg::TIME_W-1:0]         tick_time,
	input  wire  [hobb_pkg::PRICE_W-1:0]        tick_price,
	input  wire  [hobb_pkg::VOL_W-1:0]          tick_cum_volume,
	output logic                                bar_valid,
	input  wire                                 bar_ready,
	output logic [hobb_pkg::TIME_W-1:0]         bar_start,
	output logic [hobb_pkg::TIME_W-1:0]         bar_end,
	output logic [hobb_pkg::PRICE_W-1:0]        open_price,
	output logic [hobb_pkg::PRICE_W-1:0]        high_price,
	output logic [hobb_pkg::PRICE_W-1:0]        low_price,
	output logic [hobb_pkg::PRICE_W-1:0]        close_price,
	output logic signed [hobb_pkg::VOLD_W-1:0]  volume_traded
);
	import hobb_pkg::*;

	logic              resume_enable_q;
	logic [TIME_W-1:0] resume_time_q;
	logic [TIME_W-1:0] bar_seconds_q;
	hobb_cfg_t         cfg;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resume_enable_q <= 1'b0;
			resume_time_q   <= '0;
			bar_seconds_q   <= BAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESUME_ENABLE: resume_enable_q <= cfg_data[0];
				REG_RESUME_TIME:   resume_time_q   <= cfg_data[TIME_W-1:0];
				REG_BAR_SECONDS:   bar_seconds_q   <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp the bar length into one minute .. one day
	always_comb begin
		cfg.resume_enable = resume_enable_q;
		cfg.resume_time   = resume_time_q;
		if (bar_seconds_q < BAR_MIN) cfg.bar_len = BAR_MIN;
		else if (bar_seconds_q > BAR_MAX) cfg.bar_len = BAR_MAX;
		else cfg.bar_len = bar_seconds_q;
	end

	hobb_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.tick_valid     (tick_valid),
		.tick_ready     (tick_ready),
		.tick_time      (tick_time),
		.tick_price     (tick_price),
		.tick_cum_volume(tick_cum_volume),
		.bar_valid      (bar_valid),
		.bar_ready      (bar_ready),
		.bar_start      (bar_start),
		.bar_end        (bar_end),
		.open_price     (open_price),
		.high_price     (high_price),
		.low_price      (low_price),
		.close_price    (close_price),
		.volume_traded  (volume_traded)
	);

endmodule

`default_nettype wire

>>> tb/ohlc_bar_checker.sv
// Checker for the hourly OHLC bar builder: watches the register port and both
// channels, folds accepted ticks into predicted bars and compares every bar.
// Depends on hobb_pkg for field widths and register indexes.
`timescale 1ns / 1ps

module ohlc_bar_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [hobb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [hobb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                 tick_valid,
	input  wire                                 tick_ready,
	input  wire  [hobb_pkg::TIME_W-1:0]         tick_time,
	input  wire  [hobb_pkg::PRICE_W-1:0]        tick_price,
	input  wire  [hobb_pkg::VOL_W-1:0]          tick_cum_volume,
	input  wire                                 bar_valid,
	input  wire                                 bar_ready,
	input  wire  [hobb_pkg::TIME_W-1:0]         bar_start,
	input  wire  [hobb_pkg::TIME_W-1:0]         bar_end,
	input  wire  [hobb_pkg::PRICE_W-1:0]        open_price,
	input  wire  [hobb_pkg::PRICE_W-1:0]        high_price,
	input  wire  [hobb_pkg::PRICE_W-1:0]        low_price,
	input  wire  [hobb_pkg::PRICE_W-1:0]        close_price,
	input  wire  signed [hobb_pkg::VOLD_W-1:0]  volume_traded,
	output int                                  pending,
	output int                                  fail_count
);
	import hobb_pkg::*;

	localparam int unsigned SEC_PER_MIN = 60;
	localparam int unsigned SEC_PER_DAY = 86400;
	localparam int unsigned LEN_FLOOR   = 60;
	localparam int unsigned LEN_CEIL    = 86400;
	localparam int unsigned LEN_AT_RST  = 3600;

	typedef struct packed {
		logic [TIME_W-1:0]  t_start;
		logic [TIME_W-1:0]  t_end;
		logic [PRICE_W-1:0] px_open;
		logic [PRICE_W-1:0] px_high;
		logic [PRICE_W-1:0] px_low;
		logic [PRICE_W-1:0] px_close;
		logic [VOLD_W-1:0]  vol;
	} bar_rec_t;

	// register copies
	logic              resume_en;
	logic [TIME_W-1:0] resume_at;
	logic [TIME_W-1:0] bar_secs;

	// open window and running bar
	logic               win_open;
	logic               has_ticks;
	logic [WIN_W-1:0]   win_start;
	logic [WIN_W-1:0]   win_end;
	logic [PRICE_W-1:0] p_first;
	logic [PRICE_W-1:0] p_max;
	logic [PRICE_W-1:0] p_min;
	logic [PRICE_W-1:0] p_last;
	logic [VOL_W-1:0]   v_first;
	logic [VOL_W-1:0]   v_last;

	bar_rec_t predicted_bars[$];

	function automatic int unsigned bar_length();
		if (bar_secs < LEN_FLOOR) begin
			return LEN_FLOOR;
		end
		if (bar_secs > LEN_CEIL) begin
			return LEN_CEIL;
		end
		return bar_secs;
	endfunction

	task automatic clear_predictor();
		resume_en = 1'b0;
		resume_at = '0;
		bar_secs  = TIME_W'(LEN_AT_RST);
		win_open  = 1'b0;
		has_ticks = 1'b0;
		win_start = '0;
		win_end   = '0;
		p_first   = '0;
		p_max     = '0;
		p_min     = '0;
		p_last    = '0;
		v_first   = '0;
		v_last    = '0;
		predicted_bars.delete();
	endtask

	task automatic seed_bar(input logic [PRICE_W-1:0] px, input logic [VOL_W-1:0] vol);
		has_ticks = 1'b1;
		p_first   = px;
		p_max     = px;
		p_min     = px;
		p_last    = px;
		v_first   = vol;
		v_last    = vol;
	endtask

	// fold one accepted tick into the running bar; queue the bar it closes
	task automatic fold_tick(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] px,
			input logic [VOL_W-1:0] vol);
		int unsigned len;
		int unsigned tt;
		int unsigned skip;
		bar_rec_t    b;
		len = bar_length();
		tt  = t;
		// drop ticks before the resume point
		if (resume_en && t < resume_at) begin
			return;
		end
		// first kept tick opens a window on the minute
		if (!win_open) begin
			win_start = WIN_W'(tt - tt % SEC_PER_MIN);
			win_end   = WIN_W'(win_start + len);
			win_open  = 1'b1;
			seed_bar(px, vol);
			return;
		end
		// drop late ticks
		if (tt < win_start) begin
			return;
		end
		// tick inside the window
		if (tt < win_end) begin
			if (!has_ticks) begin
				seed_bar(px, vol);
			end else begin
				if (px > p_max) begin
					p_max = px;
				end
				if (px < p_min) begin
					p_min = px;
				end
				p_last = px;
				v_last = vol;
			end
			return;
		end
		// close the window and emit it
		if (has_ticks) begin
			b.t_start  = TIME_W'(win_start % SEC_PER_DAY);
			b.t_end    = TIME_W'(win_end % SEC_PER_DAY);
			b.px_open  = p_first;
			b.px_high  = p_max;
			b.px_low   = p_min;
			b.px_close = p_last;
			b.vol      = {1'b0, v_last} - {1'b0, v_first};
			predicted_bars = {predicted_bars, b};
		end
		// advance past empty windows
		skip      = (tt - win_end) / len;
		win_start = WIN_W'(win_end + skip * len);
		win_end   = WIN_W'(win_start + len);
		seed_bar(px, vol);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// compare completed bar transfers, then predict from tick transfers
	always @(posedge clk or negedge arst_n) begin
		bar_rec_t want;
		if (!arst_n) begin
			clear_predictor();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RESUME_ENABLE: begin
						resume_en = cfg_data[0];
					end
					REG_RESUME_TIME: begin
						resume_at = cfg_data[TIME_W-1:0];
					end
					REG_BAR_SECONDS: begin
						bar_secs = cfg_data[TIME_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (bar_valid && bar_ready) begin
				if (predicted_bars.size() == 0) begin
					$error("bar transfer with no bar predicted: start %0d end %0d",
						bar_start, bar_end);
					fail_count++;
				end else begin
					want = predicted_bars.pop_front();
					check_field("bar_start", want.t_start, bar_start);
					check_field("bar_end", want.t_end, bar_end);
					check_field("open_price", want.px_open, open_price);
					check_field("high_price", want.px_high, high_price);
					check_field("low_price", want.px_low, low_price);
					check_field("close_price", want.px_close, close_price);
					check_field("volume_traded", want.vol, volume_traded[VOLD_W-1:0]);
				end
			end
			if (tick_valid && tick_ready) begin
				fold_tick(tick_time, tick_price, tick_cum_volume);
			end
			pending <= predicted_bars.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the bar builder testbench: clock, reset, register writes, tick
// stimulus, bar back-pressure, watchdog and verdict.
// Depends on hobb_pkg, hourly_ohlc_bar_builder and ohlc_bar_checker.
`timescale 1ns / 1ps

module tb_top;
	import hobb_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int TIME_CAP      = 42000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	logic                      clk;
	logic                      arst_n          = 1'b0;
	logic                      cfg_we          = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index       = '0;
	logic [CFG_DATA_W-1:0]     cfg_data        = '0;
	logic                      tick_valid      = 1'b0;
	logic                      tick_ready;
	logic [TIME_W-1:0]         tick_time       = '0;
	logic [PRICE_W-1:0]        tick_price      = '0;
	logic [VOL_W-1:0]          tick_cum_volume = '0;
	logic                      bar_valid;
	logic                      bar_ready       = 1'b0;
	logic [TIME_W-1:0]         bar_start;
	logic [TIME_W-1:0]         bar_end;
	logic [PRICE_W-1:0]        open_price;
	logic [PRICE_W-1:0]        high_price;
	logic [PRICE_W-1:0]        low_price;
	logic [PRICE_W-1:0]        close_price;
	logic signed [VOLD_W-1:0]  volume_traded;

	int                        pending;
	int                        fail_count;
	int                        stall_cycles;
	int                        send_pct = 0;
	int                        recv_pct = 0;
	int                        now;
	logic [VOL_W-1:0]          cum_vol;

	hourly_ohlc_bar_builder i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.tick_valid      (tick_valid),
		.tick_ready      (tick_ready),
		.tick_time       (tick_time),
		.tick_price      (tick_price),
		.tick_cum_volume (tick_cum_volume),
		.bar_valid       (bar_valid),
		.bar_ready       (bar_ready),
		.bar_start       (bar_start),
		.bar_end         (bar_end),
		.open_price      (open_price),
		.high_price      (high_price),
		.low_price       (low_price),
		.close_price     (close_price),
		.volume_traded   (volume_traded)
	);

	ohlc_bar_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.tick_valid      (tick_valid),
		.tick_ready      (tick_ready),
		.tick_time       (tick_time),
		.tick_price      (tick_price),
		.tick_cum_volume (tick_cum_volume),
		.bar_valid       (bar_valid),
		.bar_ready       (bar_ready),
		.bar_start       (bar_start),
		.bar_end         (bar_end),
		.open_price      (open_price),
		.high_price      (high_price),
		.low_price       (low_price),
		.close_price     (close_price),
		.volume_traded   (volume_traded),
		.pending         (pending),
		.fail_count      (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random back-pressure on the bar channel
	always @(posedge clk) begin
		bar_ready <= ($urandom_range(99) >= recv_pct);
	end

	// end the run when no transfer happens for too long
	initial begin : watchdog
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick_valid && tick_ready) || (bar_valid && bar_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// one tick transfer; valid stays high across back-to-back ticks
	task automatic send_tick(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] px,
			input logic [VOL_W-1:0] vol);
		if ($urandom_range(99) < send_pct) begin
			tick_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_pct);
		end
		tick_valid      <= 1'b1;
		tick_time       <= t;
		tick_price      <= px;
		tick_cum_volume <= vol;
		@(posedge clk);
		while (!tick_ready) @(posedge clk);
	endtask

	// hold the sender until every predicted bar has arrived and the block is quiet
	task automatic settle();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// forward-moving ticks with random content, some late ticks and empty windows
	task automatic run_phase(input int items, input int step_max, input int span);
		int                kept;
		int                back;
		int                pick;
		logic [TIME_W-1:0] t;
		kept = 0;
		while (kept < items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				back = $urandom_range(400, 1);
				t = (now > back) ? TIME_W'(now - back) : '0;
			end else begin
				if (pick < 10) begin
					now += $urandom_range(2 * span, span);
				end else begin
					now += $urandom_range(step_max, 0);
				end
				if (now > TIME_CAP) begin
					now = TIME_CAP;
				end
				t = TIME_W'(now);
			end
			if ($urandom_range(99) < 20) begin
				cum_vol = VOL_W'({$urandom, $urandom});
			end else begin
				cum_vol += VOL_W'($urandom_range(5000, 0));
			end
			send_tick(t, PRICE_W'({$urandom, $urandom}), cum_vol);
			kept++;
		end
	endtask

	initial begin
		now     = 0;
		cum_vol = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: hour bars at reset length, resume filter at 30 s
		write_reg(REG_RESUME_ENABLE, {16'($urandom), 1'b1});
		write_reg(REG_RESUME_TIME, CFG_DATA_W'(30));
		cfg_we <= 1'b0;
		send_tick(TIME_W'(0), PRICE_W'(1), VOL_W'(1));
		send_tick(TIME_W'(29), PRICE_W'(2), VOL_W'(2));
		send_tick(TIME_W'(45), PRICE_W'(100 << 16), VOL_W'(1000));
		send_tick(TIME_W'(59), '0, '0);
		send_tick(TIME_W'(1000), '1, '1);
		send_tick(TIME_W'(3599), PRICE_W'(5 << 16), VOL_W'(500));
		// tick exactly at the window end closes it with a falling volume
		send_tick(TIME_W'(3600), PRICE_W'(7), VOL_W'(10));
		send_tick(TIME_W'(3000), PRICE_W'(9), VOL_W'(9));
		send_tick(TIME_W'(5000), '1, '0);
		// jump over one empty hour
		send_tick(TIME_W'(10805), PRICE_W'(3), VOL_W'(20));
		send_tick(TIME_W'(10805), PRICE_W'(1), '1);
		settle();

		// minute bars, no idling
		send_pct = 0;
		recv_pct = 0;
		write_reg(REG_RESUME_ENABLE, {16'($urandom), 1'b0});
		write_reg(REG_BAR_SECONDS, CFG_DATA_W'(60));
		cfg_we <= 1'b0;
		now = 14400;
		run_phase(400, 20, 60);
		settle();

		// zero length clamps to a minute, resume point just ahead; sender idles
		send_pct = 71;
		recv_pct = 0;
		write_reg(REG_BAR_SECONDS, '0);
		write_reg(REG_RESUME_ENABLE, {16'($urandom), 1'b1});
		write_reg(REG_RESUME_TIME, CFG_DATA_W'(now + 200));
		cfg_we <= 1'b0;
		run_phase(400, 20, 60);
		settle();

		// two-minute bars, resume at midnight; receiver stalls
		send_pct = 0;
		recv_pct = 71;
		write_reg(REG_BAR_SECONDS, CFG_DATA_W'(120));
		write_reg(REG_RESUME_TIME, '0);
		cfg_we <= 1'b0;
		run_phase(400, 20, 120);
		settle();

		// length just under the floor, filter off with the largest resume point
		send_pct = 17;
		recv_pct = 17;
		write_reg(REG_BAR_SECONDS, CFG_DATA_W'(59));
		write_reg(REG_RESUME_ENABLE, {16'($urandom), 1'b0});
		write_reg(REG_RESUME_TIME, '1);
		cfg_we <= 1'b0;
		run_phase(400, 20, 60);
		settle();

		// five-minute bars, late ticks filtered by the resume point
		send_pct = 0;
		recv_pct = 71;
		write_reg(REG_BAR_SECONDS, CFG_DATA_W'(300));
		write_reg(REG_RESUME_ENABLE, {16'($urandom), 1'b1});
		write_reg(REG_RESUME_TIME, CFG_DATA_W'(now));
		cfg_we <= 1'b0;
		run_phase(350, 12, 300);
		settle();

		// oversized length clamps to a day; times run past midnight
		send_pct = 17;
		recv_pct = 17;
		write_reg(REG_BAR_SECONDS, '1);
		write_reg(REG_RESUME_ENABLE, {16'($urandom), 1'b0});
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		send_tick(TIME_W'(now + 400), PRICE_W'({$urandom, $urandom}), VOL_W'(100));
		send_tick(TIME_W'(now + 405), '0, VOL_W'(200));
		send_tick(TIME_W'(90000), '1, VOL_W'(300));
		send_tick(TIME_W'(100000), PRICE_W'({$urandom, $urandom}), '1);
		send_tick('1, '1, '0);

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/hobb_pkg.sv
rtl/hobb_alu.sv
rtl/hobb_seq.sv
rtl/hourly_ohlc_bar_builder.sv
tb/ohlc_bar_checker.sv
tb/tb_top.sv
